FILE: sv/fpsa_pkg.sv
// Shared types and codes for the fit-policy segment allocator.
// No dependencies; the allocator top level and its table RAM import it.
package fpsa_pkg;

	localparam int DEF_MAX_SEGMENTS = 64;
	localparam int DEF_ADDR_BITS    = 16;
	localparam int ID_BITS          = 16;
	localparam int REQ_BITS         = 17;
	localparam int CFG_DATA_BITS    = 17;
	localparam logic [ID_BITS-1:0] ID_LAST = '1;

	typedef enum logic [3:0] {
		S_INIT,
		S_IDLE,
		S_SCAN,
		S_SHIFT,
		S_SPLIT,
		S_ALLOC,
		S_MERGE,
		S_STATS,
		S_DONE
	} seq_state_t;

	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_NO_FIT  = 2'd1,
		ST_UNKNOWN = 2'd2,
		ST_FULL    = 2'd3
	} status_t;

	typedef enum logic {
		OP_ALLOC = 1'b0,
		OP_FREE  = 1'b1
	} op_t;

	typedef enum logic [1:0] {
		POL_FIRST  = 2'd0,
		POL_BEST   = 2'd1,
		POL_WORST  = 2'd2,
		POL_UNUSED = 2'd3
	} policy_t;

	typedef enum logic {
		CFG_FIT_POLICY   = 1'b0,
		CFG_MEMORY_BYTES = 1'b1
	} cfg_index_t;

	// Read and write strobes of the segment table RAM.
	typedef struct packed {
		logic re;
		logic we;
	} ram_ctl_t;

endpackage

FILE: sv/fpsa_table.sv
// Segment table storage: one write port and one read port with registered data.
// Uses fpsa_pkg for the port strobe struct.
module fpsa_table import fpsa_pkg::*; #(
	parameter int DEPTH = DEF_MAX_SEGMENTS,
	parameter int WIDTH = 50
) (
	input  logic                     clk,
	input  ram_ctl_t                 ctl,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (ctl.we) begin
			mem[waddr] <= wdata;
		end
		if (ctl.re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

FILE: sv/fit_policy_segment_allocator.sv
// Segment allocator with first, best and worst fit and coalescing on free.
// Uses fpsa_pkg and the fpsa_table RAM.
//
// Usage: an item on the input channel is an allocate (request_size bytes) or
// a free (release_id). Each item yields exactly one result item carrying a
// status, the block address, the granted id and the free-space statistics.
// The configuration channel writes the fit policy (index 0) or the managed
// size (index 1); writing the size rebuilds the table as one free segment.
// Each item runs a scan pass and then a statistics pass. An allocate that
// splits puts a shift pass (which moves the entries above the chosen one),
// a split write and an allocate write between them; one without a split
// puts only the allocate write there, a free of a known id puts a merge
// pass there, and a rejected allocate or an unknown id puts nothing there.
// The block takes one item at a time; in_ready is high only when idle.
// A finished result sits in the output register; the block returns to idle
// and takes the next item while that result waits, and only holds its next
// result until the receiver takes the earlier one.
// After reset the block writes the initial free segment, then goes idle.
module fit_policy_segment_allocator import fpsa_pkg::*; #(
	parameter int MAX_SEGMENTS = DEF_MAX_SEGMENTS,
	parameter int ADDR_BITS    = DEF_ADDR_BITS
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     cfg_valid,
	output logic                     cfg_ready,
	input  logic                     cfg_index,
	input  logic [CFG_DATA_BITS-1:0] cfg_data,
	input  logic                     in_valid,
	output logic                     in_ready,
	input  logic                     operation,
	input  logic [REQ_BITS-1:0]      request_size,
	input  logic [ID_BITS-1:0]       release_id,
	output logic                     out_valid,
	input  logic                     out_ready,
	output logic [1:0]               status,
	output logic [ADDR_BITS-1:0]     block_address,
	output logic [ID_BITS-1:0]       granted_id,
	output logic [ADDR_BITS:0]       free_bytes,
	output logic [ADDR_BITS:0]       max_free_size
);

	localparam int IDX  = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
	localparam int CNTW = $clog2(MAX_SEGMENTS + 1);
	localparam int SZW  = ADDR_BITS + 1;
	localparam int CW   = (SZW > REQ_BITS) ? SZW : REQ_BITS;
	localparam int EW   = ADDR_BITS + SZW + 1 + ID_BITS;
	localparam logic [CW-1:0]   CAP      = CW'(1) << ADDR_BITS;
	localparam logic [CNTW-1:0] CNT_FULL = CNTW'(MAX_SEGMENTS);

	typedef struct packed {
		logic [ADDR_BITS-1:0] start;
		logic [SZW-1:0]       size;
		logic                 used;
		logic [ID_BITS-1:0]   owner;
	} seg_t;

	seq_state_t state_q, state_d;

	logic            op_q;
	logic [CW-1:0]   req_q;
	logic [ID_BITS-1:0] rid_q;
	logic [1:0]      pol_q;
	logic [SZW-1:0]  mem_bytes_q;
	logic [CNTW-1:0] cnt_q;
	logic [ID_BITS-1:0] nid_q;

	logic            found_q;
	logic [IDX-1:0]  pick_q;
	logic [SZW-1:0]  pick_size_q;
	logic [ADDR_BITS-1:0] pick_start_q;

	logic [CNTW-1:0] rd_q;
	logic            v_s1;
	logic [IDX-1:0]  idx_s1;

	seg_t            pend_q;
	logic            pend_v_q;
	logic [IDX-1:0]  w_q;

	logic [SZW-1:0]  sum_q, max_q;
	logic [1:0]      res_status_q;
	logic [ADDR_BITS-1:0] res_addr_q;
	logic [ID_BITS-1:0]   res_gid_q;

	logic            out_valid_q;
	logic [1:0]      ost_q;
	logic [ADDR_BITS-1:0] oaddr_q;
	logic [ID_BITS-1:0]   ogid_q;
	logic [SZW-1:0]  ofree_q, olarge_q;

	ram_ctl_t        ctl;
	logic [IDX-1:0]  waddr;
	seg_t            wdata;
	logic [EW-1:0]   rdata;
	seg_t            e, e2;

	logic issue, pass_end, cfg_fire, in_fire, out_load;
	logic cand, better, split, merge_pair;
	logic [SZW-1:0]  cfg_clamped;
	logic [CW-1:0]   cfg_ext;

	assign e = seg_t'(rdata);

	// In the merge pass the released entry is seen as already free.
	always_comb begin
		e2 = e;
		if (idx_s1 == pick_q) begin
			e2.used  = 1'b0;
			e2.owner = '0;
		end
	end

	assign cfg_ready = (state_q == S_IDLE);
	assign in_ready  = (state_q == S_IDLE) && !cfg_valid;
	assign cfg_fire  = cfg_valid && cfg_ready;
	assign in_fire   = in_valid && in_ready;
	assign out_load  = (state_q == S_DONE) && (!out_valid_q || out_ready);

	always_comb begin
		cfg_ext = CW'(cfg_data);
		if (cfg_ext == '0) begin
			cfg_clamped = SZW'(1);
		end else if (cfg_ext > CAP) begin
			cfg_clamped = SZW'(CAP);
		end else begin
			cfg_clamped = SZW'(cfg_ext);
		end
	end

	always_comb begin
		unique case (state_q)
			S_SCAN, S_MERGE, S_STATS: issue = (rd_q < cnt_q);
			S_SHIFT:                  issue = (rd_q > CNTW'(pick_q));
			default:                  issue = 1'b0;
		endcase
	end
	assign pass_end = !issue && !v_s1;

	// Candidate test of the shared compare unit during the scan.
	assign cand = !e.used && (CW'(e.size) >= req_q);
	always_comb begin
		unique case (policy_t'(pol_q))
			POL_FIRST:  better = !found_q;
			POL_BEST:   better = !found_q || (e.size < pick_size_q);
			POL_WORST:  better = !found_q || (e.size > pick_size_q);
			default:    better = 1'b0;
		endcase
	end
	assign split      = CW'(pick_size_q) > req_q;
	assign merge_pair = !pend_q.used && !e2.used;

	// Table write port.
	always_comb begin
		ctl.re = issue;
		ctl.we = 1'b0;
		waddr  = '0;
		wdata  = '0;
		unique case (state_q)
			S_INIT: begin
				ctl.we     = 1'b1;
				wdata.size = mem_bytes_q;
			end
			S_IDLE: begin
				if (cfg_fire && cfg_index == CFG_MEMORY_BYTES) begin
					ctl.we     = 1'b1;
					wdata.size = cfg_clamped;
				end
			end
			S_SHIFT: begin
				ctl.we = v_s1;
				waddr  = idx_s1 + 1'b1;
				wdata  = e;
			end
			S_SPLIT: begin
				ctl.we      = 1'b1;
				waddr       = pick_q + 1'b1;
				wdata.start = pick_start_q + ADDR_BITS'(req_q);
				wdata.size  = pick_size_q - SZW'(req_q);
			end
			S_ALLOC: begin
				ctl.we      = 1'b1;
				waddr       = pick_q;
				wdata.start = pick_start_q;
				wdata.size  = SZW'(req_q);
				wdata.used  = 1'b1;
				wdata.owner = nid_q;
			end
			S_MERGE: begin
				waddr = w_q;
				wdata = pend_q;
				if (v_s1) begin
					ctl.we = pend_v_q && !merge_pair;
				end else if (!issue) begin
					ctl.we = 1'b1;
				end
			end
			default: ;
		endcase
	end

	fpsa_table #(
		.DEPTH (MAX_SEGMENTS),
		.WIDTH (EW)
	) u_table (
		.clk   (clk),
		.ctl   (ctl),
		.waddr (waddr),
		.wdata (wdata),
		.raddr (rd_q[IDX-1:0]),
		.rdata (rdata)
	);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_INIT: state_d = S_IDLE;
			S_IDLE: begin
				if (in_fire) begin
					state_d = S_SCAN;
				end
			end
			S_SCAN: begin
				if (pass_end) begin
					if (op_q == OP_ALLOC) begin
						if (!found_q || req_q == '0) begin
							state_d = S_STATS;
						end else if (split && cnt_q == CNT_FULL) begin
							state_d = S_STATS;
						end else if (split) begin
							state_d = S_SHIFT;
						end else begin
							state_d = S_ALLOC;
						end
					end else if (!found_q || rid_q == '0) begin
						state_d = S_STATS;
					end else begin
						state_d = S_MERGE;
					end
				end
			end
			S_SHIFT: begin
				if (pass_end) begin
					state_d = S_SPLIT;
				end
			end
			S_SPLIT: state_d = S_ALLOC;
			S_ALLOC: state_d = S_STATS;
			S_MERGE: begin
				if (pass_end) begin
					state_d = S_STATS;
				end
			end
			S_STATS: begin
				if (pass_end) begin
					state_d = S_DONE;
				end
			end
			S_DONE: begin
				if (out_load) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_INIT;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			op_q         <= OP_ALLOC;
			req_q        <= '0;
			rid_q        <= '0;
			pol_q        <= POL_FIRST;
			mem_bytes_q  <= SZW'(CAP);
			cnt_q        <= CNTW'(1);
			nid_q        <= ID_BITS'(1);
			found_q      <= 1'b0;
			pick_q       <= '0;
			pick_size_q  <= '0;
			pick_start_q <= '0;
			rd_q         <= '0;
			v_s1         <= 1'b0;
			idx_s1       <= '0;
			pend_q       <= '0;
			pend_v_q     <= 1'b0;
			w_q          <= '0;
			sum_q        <= '0;
			max_q        <= '0;
			res_status_q <= ST_OK;
			res_addr_q   <= '0;
			res_gid_q    <= '0;
			out_valid_q  <= 1'b0;
			ost_q        <= ST_OK;
			oaddr_q      <= '0;
			ogid_q       <= '0;
			ofree_q      <= '0;
			olarge_q     <= '0;
		end else begin
			v_s1   <= issue;
			idx_s1 <= rd_q[IDX-1:0];
			if (state_d != state_q) begin
				rd_q <= (state_d == S_SHIFT) ? cnt_q - 1'b1 : '0;
			end else if (issue) begin
				rd_q <= (state_q == S_SHIFT) ? rd_q - 1'b1 : rd_q + 1'b1;
			end

			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end

			unique case (state_q)
				S_INIT: begin
					cnt_q <= CNTW'(1);
					nid_q <= ID_BITS'(1);
				end
				S_IDLE: begin
					if (cfg_fire) begin
						if (cfg_index == CFG_FIT_POLICY) begin
							pol_q <= cfg_data[1:0];
						end else begin
							mem_bytes_q <= cfg_clamped;
							cnt_q       <= CNTW'(1);
							nid_q       <= ID_BITS'(1);
						end
					end
					if (in_fire) begin
						op_q         <= operation;
						req_q        <= CW'(request_size);
						rid_q        <= release_id;
						found_q      <= 1'b0;
						res_status_q <= ST_OK;
						res_addr_q   <= '0;
						res_gid_q    <= '0;
					end
				end
				S_SCAN: begin
					if (v_s1) begin
						if (op_q == OP_ALLOC) begin
							if (cand && better) begin
								found_q      <= 1'b1;
								pick_q       <= idx_s1;
								pick_size_q  <= e.size;
								pick_start_q <= e.start;
							end
						end else if (e.used && e.owner == rid_q && !found_q) begin
							found_q      <= 1'b1;
							pick_q       <= idx_s1;
							pick_start_q <= e.start;
						end
					end
					if (pass_end) begin
						if (op_q == OP_ALLOC) begin
							if (!found_q || req_q == '0) begin
								res_status_q <= ST_NO_FIT;
							end else if (split && cnt_q == CNT_FULL) begin
								res_status_q <= ST_FULL;
							end
						end else if (!found_q || rid_q == '0) begin
							res_status_q <= ST_UNKNOWN;
						end else begin
							res_addr_q <= pick_start_q;
						end
						pend_v_q <= 1'b0;
						w_q      <= '0;
					end
				end
				S_SPLIT: begin
					cnt_q <= cnt_q + 1'b1;
				end
				S_ALLOC: begin
					res_addr_q <= pick_start_q;
					res_gid_q  <= nid_q;
					nid_q      <= (nid_q == ID_LAST) ? ID_BITS'(1) : nid_q + 1'b1;
				end
				S_MERGE: begin
					if (v_s1) begin
						if (!pend_v_q) begin
							pend_q   <= e2;
							pend_v_q <= 1'b1;
						end else if (merge_pair) begin
							pend_q.size <= pend_q.size + e2.size;
						end else begin
							pend_q <= e2;
							w_q    <= w_q + 1'b1;
						end
					end else if (!issue) begin
						cnt_q <= CNTW'(w_q) + 1'b1;
					end
				end
				S_STATS: begin
					if (v_s1 && !e.used) begin
						sum_q <= sum_q + e.size;
						if (e.size > max_q) begin
							max_q <= e.size;
						end
					end
				end
				S_DONE: begin
					if (out_load) begin
						ost_q    <= res_status_q;
						oaddr_q  <= res_addr_q;
						ogid_q   <= res_gid_q;
						ofree_q  <= sum_q;
						olarge_q <= max_q;
					end
				end
				default: ;
			endcase

			if (state_d == S_STATS && state_q != S_STATS) begin
				sum_q <= '0;
				max_q <= '0;
			end
		end
	end

	assign out_valid     = out_valid_q;
	assign status        = ost_q;
	assign block_address = oaddr_q;
	assign granted_id    = ogid_q;
	assign free_bytes    = ofree_q;
	assign max_free_size = olarge_q;

endmodule

FILE: tb/tb_fit_policy_segment_allocator.sv
// Self-checking testbench for the fit-policy segment allocator.
// Depends on fpsa_pkg and fit_policy_segment_allocator; a behavioral segment
// table predicts each result, which is compared field by field.
`timescale 1ns / 1ps

module tb_fit_policy_segment_allocator;
	import fpsa_pkg::*;

	localparam int NSEG     = DEF_MAX_SEGMENTS;
	localparam int MEM_CAP  = 1 << DEF_ADDR_BITS;
	localparam int WD_LIMIT = 20000;

	typedef struct {
		logic [16:0] start;
		logic [16:0] len;
		bit          used;
		logic [15:0] owner;
	} segment_t;

	typedef struct {
		status_t     st;
		logic [15:0] addr;
		logic [15:0] gid;
		logic [16:0] freeb;
		logic [16:0] big;
	} alloc_result_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic        cfg_index = 1'b0;
	logic [16:0] cfg_data = '0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic        operation = 1'b0;
	logic [16:0] request_size = '0;
	logic [15:0] release_id = '0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [1:0]  status;
	logic [15:0] block_address;
	logic [15:0] granted_id;
	logic [16:0] free_bytes;
	logic [16:0] max_free_size;

	// Shadow copy of the allocator state.
	segment_t    seg_tab[NSEG];
	int          seg_cnt;
	logic [15:0] next_id;
	policy_t     cur_policy;
	int          mem_size;

	alloc_result_t expected_results[$];
	logic [15:0]   held_ids[$];
	int  mismatches = 0;
	int  quiet_cycles = 0;
	bit  send_idle = 1'b1;
	bit  recv_idle = 1'b1;
	int  recv_stall = 0;

	always #5 clk = ~clk;

	fit_policy_segment_allocator uut (
		.clk(clk), .arst_n(arst_n),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_ready(in_ready),
		.operation(operation), .request_size(request_size), .release_id(release_id),
		.out_valid(out_valid), .out_ready(out_ready),
		.status(status), .block_address(block_address), .granted_id(granted_id),
		.free_bytes(free_bytes), .max_free_size(max_free_size)
	);

	function automatic void rebuild_shadow();
		foreach (seg_tab[i]) seg_tab[i] = '{default: '0};
		seg_tab[0].len = 17'(mem_size);
		seg_cnt = 1;
		next_id = 16'd1;
		held_ids.delete();
	endfunction

	function automatic alloc_result_t predict_result(op_t op, logic [16:0] req,
			logic [15:0] rid);
		alloc_result_t r;
		int pick, k;
		logic [16:0] bv;
		r = '{st: ST_OK, addr: '0, gid: '0, freeb: '0, big: '0};
		pick = -1;
		bv = '0;
		if (op == OP_ALLOC) begin
			if (req != 0 && cur_policy != POL_UNUSED) begin
				for (int i = 0; i < seg_cnt; i++) begin
					if (seg_tab[i].used || seg_tab[i].len < req) continue;
					if (cur_policy == POL_FIRST) begin
						pick = i;
						break;
					end
					if (pick < 0 || (cur_policy == POL_BEST && seg_tab[i].len < bv) ||
							(cur_policy == POL_WORST && seg_tab[i].len > bv)) begin
						pick = i;
						bv = seg_tab[i].len;
					end
				end
			end
			if (pick < 0) begin
				r.st = ST_NO_FIT;
			end else begin
				k = pick;
				if (seg_tab[k].len > req) begin
					if (seg_cnt >= NSEG) begin
						r.st = ST_FULL;
					end else begin
						for (int j = seg_cnt; j > k + 1; j--) seg_tab[j] = seg_tab[j-1];
						seg_tab[k+1] = '{start: seg_tab[k].start + req,
							len: seg_tab[k].len - req, used: 1'b0, owner: '0};
						seg_tab[k].len = req;
						seg_cnt++;
					end
				end
				if (r.st == ST_OK) begin
					seg_tab[k].used = 1'b1;
					seg_tab[k].owner = next_id;
					r.gid = next_id;
					r.addr = seg_tab[k].start[15:0];
					held_ids.insert(held_ids.size(), next_id);
					next_id = (next_id == ID_LAST) ? 16'd1 : next_id + 16'd1;
				end
			end
		end else begin
			for (int i = 0; i < seg_cnt; i++) begin
				if (seg_tab[i].used && seg_tab[i].owner == rid) begin
					pick = i;
					break;
				end
			end
			if (pick < 0 || rid == 0) begin
				r.st = ST_UNKNOWN;
			end else begin
				seg_tab[pick].used = 1'b0;
				seg_tab[pick].owner = '0;
				r.addr = seg_tab[pick].start[15:0];
				foreach (held_ids[i]) begin
					if (held_ids[i] == rid) begin
						held_ids.delete(i);
						break;
					end
				end
				// Coalesce every run of adjacent free segments.
				k = 0;
				while (k + 1 < seg_cnt) begin
					if (!seg_tab[k].used && !seg_tab[k+1].used) begin
						seg_tab[k].len += seg_tab[k+1].len;
						for (int j = k + 1; j < seg_cnt - 1; j++) seg_tab[j] = seg_tab[j+1];
						seg_cnt--;
						seg_tab[seg_cnt] = '{default: '0};
					end else begin
						k++;
					end
				end
			end
		end
		for (int i = 0; i < seg_cnt; i++) begin
			if (!seg_tab[i].used) begin
				r.freeb += seg_tab[i].len;
				if (seg_tab[i].len > r.big) r.big = seg_tab[i].len;
			end
		end
		return r;
	endfunction

	task automatic send_item(op_t op, logic [16:0] req, logic [15:0] rid);
		int gap;
		gap = send_idle ? $urandom_range(0, 19) : 0;
		@(negedge clk);
		if (gap > 0) begin
			in_valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		operation = op;
		request_size = req;
		release_id = rid;
		in_valid = 1'b1;
		do @(posedge clk); while (!in_ready);
		expected_results.insert(expected_results.size(), predict_result(op, req, rid));
	endtask

	task automatic drain();
		@(negedge clk);
		in_valid = 1'b0;
		while (expected_results.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	task automatic write_reg(cfg_index_t idx, logic [16:0] value);
		drain();
		@(negedge clk);
		cfg_index = idx;
		cfg_data = value;
		cfg_valid = 1'b1;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid = 1'b0;
		if (idx == CFG_FIT_POLICY) begin
			cur_policy = policy_t'(value[1:0]);
		end else begin
			mem_size = (value == 0) ? 1 : (int'(value) > MEM_CAP ? MEM_CAP : int'(value));
			rebuild_shadow();
		end
	endtask

	// Receiver: random stall per result, released at the falling edge.
	always @(negedge clk) begin
		if (recv_stall > 0) begin
			out_ready <= 1'b0;
			recv_stall <= recv_stall - 1;
		end else begin
			out_ready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		alloc_result_t e;
		if (arst_n && out_valid && out_ready) begin
			recv_stall <= recv_idle ? $urandom_range(0, 19) : 0;
			if (expected_results.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected result item, status %0d", status);
			end else begin
				e = expected_results.pop_front();
				if (status != e.st || block_address != e.addr || granted_id != e.gid ||
						free_bytes != e.freeb || max_free_size != e.big) begin
					mismatches++;
					if (mismatches <= 10)
						$display({"mismatch: exp st %0d addr %0d id %0d free %0d big %0d,",
							" got %0d %0d %0d %0d %0d"},
							e.st, e.addr, e.gid, e.freeb, e.big,
							status, block_address, granted_id, free_bytes, max_free_size);
				end
			end
		end
	end

	// Watchdog on cycles in which no channel moves an item.
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WD_LIMIT) begin
			$display("[fit_policy_segment_allocator] ERROR");
			$finish;
		end
	end

	task automatic test_edges();
		send_item(OP_ALLOC, 17'd0, 16'd0);
		send_item(OP_ALLOC, 17'd65537, 16'hFFFF);
		send_item(OP_ALLOC, 17'h1FFFF, 16'd0);
		send_item(OP_FREE, 17'd5, 16'd0);
		send_item(OP_FREE, 17'd5, 16'd1);
		send_item(OP_ALLOC, 17'd65536, 16'd0);
		send_item(OP_ALLOC, 17'd1, 16'd0);
		send_item(OP_FREE, 17'd0, 16'd1);
		send_item(OP_ALLOC, 17'd1, 16'd0);
		send_item(OP_ALLOC, 17'd100, 16'd0);
		send_item(OP_FREE, 17'h1FFFF, 16'd2);
		send_item(OP_FREE, 17'd0, 16'hFFFF);
	endtask

	task automatic test_fit_ties();
		write_reg(CFG_MEMORY_BYTES, 17'd64);
		repeat (5) send_item(OP_ALLOC, 17'd8, 16'd0);
		send_item(OP_FREE, 17'd0, 16'd1);
		send_item(OP_FREE, 17'd0, 16'd3);
		write_reg(CFG_FIT_POLICY, 17'(POL_BEST));
		send_item(OP_ALLOC, 17'd4, 16'd0);
		write_reg(CFG_FIT_POLICY, 17'(POL_WORST));
		send_item(OP_ALLOC, 17'd4, 16'd0);
		write_reg(CFG_FIT_POLICY, 17'(POL_UNUSED));
		send_item(OP_ALLOC, 17'd1, 16'd0);
		send_item(OP_FREE, 17'd0, 16'd2);
		write_reg(CFG_FIT_POLICY, 17'(POL_FIRST));
		send_item(OP_ALLOC, 17'd8, 16'd0);
	endtask

	task automatic test_full_table();
		write_reg(CFG_MEMORY_BYTES, 17'd100);
		repeat (NSEG - 1) send_item(OP_ALLOC, 17'd1, 16'd0);
		send_item(OP_ALLOC, 17'd1, 16'd0);
		send_item(OP_ALLOC, 17'd37, 16'd0);
		send_item(OP_FREE, 17'd0, 16'd10);
		send_item(OP_FREE, 17'd0, 16'd11);
		send_item(OP_ALLOC, 17'd2, 16'd0);
	endtask

	task automatic test_mem_clamp();
		write_reg(CFG_MEMORY_BYTES, 17'd0);
		send_item(OP_ALLOC, 17'd2, 16'd0);
		send_item(OP_ALLOC, 17'd1, 16'd0);
		write_reg(CFG_MEMORY_BYTES, 17'h1FFFF);
		send_item(OP_ALLOC, 17'd65536, 16'd0);
	endtask

	task automatic run_random(int count);
		int pick;
		logic [16:0] req;
		for (int n = 0; n < count; n++) begin
			pick = $urandom_range(0, 99);
			if (pick < 55) begin
				case ($urandom_range(0, 9))
					0: req = 17'($urandom());
					1, 2: req = 17'($urandom_range(1, mem_size));
					default: req = 17'($urandom_range(1, mem_size / 8 + 1));
				endcase
				send_item(OP_ALLOC, req, 16'($urandom()));
			end else if (pick < 90 && held_ids.size() != 0) begin
				send_item(OP_FREE, 17'($urandom()),
					held_ids[$urandom_range(0, held_ids.size() - 1)]);
			end else begin
				send_item(OP_FREE, 17'($urandom()), 16'($urandom()));
			end
		end
	endtask

	task automatic test_random();
		logic [16:0] sizes[5] = '{17'd65536, 17'd1000, 17'd4097, 17'd300, 17'h1FFFF};
		foreach (sizes[s]) begin
			write_reg(CFG_MEMORY_BYTES, sizes[s]);
			for (int p = 0; p < 4; p++) begin
				write_reg(CFG_FIT_POLICY, (p == 3) ? 17'h1FFFE : 17'(p));
				send_idle = $urandom_range(0, 3) != 0;
				recv_idle = $urandom_range(0, 3) != 0;
				run_random(p == 3 ? 6 : 20);
			end
		end
		send_idle = 1'b1;
		recv_idle = 1'b1;
	endtask

	initial begin
		cur_policy = POL_FIRST;
		mem_size = MEM_CAP;
		rebuild_shadow();
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		test_edges();
		test_fit_ties();
		test_full_table();
		test_mem_clamp();
		test_random();
		drain();
		repeat (200) @(posedge clk);
		if (mismatches == 0 && expected_results.size() == 0)
			$display("[fit_policy_segment_allocator] OK");
		else
			$display("[fit_policy_segment_allocator] ERROR");
		$finish;
	end

endmodule
